/* design/rag_pkg.sv */
// Shared types, codes and helpers for the Pade residual and gradient block.
package rag_pkg;

   localparam int DEF_MAX_TERMS = 16;
   localparam int DEF_FRAC_BITS = 16;
   // Address fields in the command are sized for the largest table.
   localparam int IDX_W = 7;
   localparam int ACC_W = 72;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;
   localparam logic KIND_RES = 1'b0;
   localparam logic KIND_DER = 1'b1;

   localparam logic CSR_NUM_TERMS = 1'b0;
   localparam logic CSR_DEN_TERMS = 1'b1;

   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_START    = 4'd2;
   localparam logic [3:0] OP_POW_MUL  = 4'd3;
   localparam logic [3:0] OP_POW_WR   = 4'd4;
   localparam logic [3:0] OP_RD       = 4'd5;
   localparam logic [3:0] OP_TERM_MUL = 4'd6;
   localparam logic [3:0] OP_TERM_ACC = 4'd7;
   localparam logic [3:0] OP_FINISH   = 4'd8;
   localparam logic [3:0] OP_DIV_NUM  = 4'd9;
   localparam logic [3:0] OP_DIV_PW   = 4'd10;
   localparam logic [3:0] OP_DIV_T    = 4'd11;
   localparam logic [3:0] OP_F_SAVE   = 4'd12;
   localparam logic [3:0] OP_FMUL     = 4'd13;
   localparam logic [3:0] OP_T_SAVE   = 4'd14;
   localparam logic [3:0] OP_EMIT     = 4'd15;

   localparam logic [1:0] VS_ZERO = 2'd0;
   localparam logic [1:0] VS_RES  = 2'd1;
   localparam logic [1:0] VS_QPOS = 2'd2;
   localparam logic [1:0] VS_QNEG = 2'd3;

   typedef struct packed {
      logic [3:0]       op;
      logic [IDX_W-1:0] coef_addr;
      logic [IDX_W-1:0] pw_addr;
      logic             acc_den;
      logic [1:0]       vsel;
      logic             kind;
      logic [3:0]       term_index;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic div_busy;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } sat_type;

   function automatic sat_type sat32(input logic signed [ACC_W-1:0] v);
      sat_type r;
      logic    fits;
      fits = (&v[ACC_W-1:31]) | ~(|v[ACC_W-1:31]);
      r.ovf = ~fits;
      if (fits) begin
         r.val = v[31:0];
      end else if (v[ACC_W-1]) begin
         r.val = 32'sh8000_0000;
      end else begin
         r.val = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

/* design/rag_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rag_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rag_dp.sv */
// Datapath: coefficient and power tables, shared multiplier, divider, output register.
module rag_dp import rag_pkg::*; #(
   parameter int MAX_TERMS = DEF_MAX_TERMS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [3:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [3:0]         rsp_term_index,
   output logic signed [31:0] rsp_value,
   output logic               rsp_div_error,
   output logic               rsp_last
);

   localparam int CW       = $clog2(MAX_TERMS);
   localparam int PW_DEPTH = MAX_TERMS + 1;
   localparam int PAW      = $clog2(PW_DEPTH);
   localparam logic [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);
   localparam logic [63:0] HALF  = 64'd1 << (FRAC_BITS - 1);

   logic signed [31:0] x_ff, y_ff, pw_cur_ff, numq_ff, den_ff, f_ff, t_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_num_ff, acc_den_ff;
   logic common_ff, own_ff;
   logic [MAX_TERMS-1:0] coef_vld_ff;
   logic coef_vld_rd_ff;

   logic dneg_ff, dbusy_ff, dprep_ff, dovf_ff;
   logic [31:0] dub_ff, drem_ff, dlo_ff, dq_ff;
   logic [5:0]  dcnt_ff;

   logic rsp_valid_ff, rsp_kind_ff, rsp_err_ff, rsp_last_ff;
   logic [3:0] rsp_idx_ff;
   logic signed [31:0] rsp_value_ff;

   // Table ports
   logic        coef_wr;
   logic [31:0] coef_rd, pw_rd, pw_wdata;
   logic        pw_wr;
   logic [PAW-1:0] pw_waddr;
   logic signed [31:0] coef_eff;

   // Rounded product
   logic [63:0] mag, rmag;
   logic [ACC_W-1:0] rnd_pos, rnd_u;
   logic signed [ACC_W-1:0] rnd;
   sat_type rnd_sat, num_sat, den_sat, res_sat;

   logic signed [31:0] mul_a, mul_b;
   logic signed [31:0] div_src;
   logic [31:0] ua, ub;
   logic [63:0] dividend;
   logic [32:0] dstep;
   logic signed [31:0] div_val, neg_val;
   logic div_sat, neg_sat;
   logic out_free;

   assign coef_wr = (cmd.op == OP_LOAD) && (32'(req_coef_index) < MAX_TERMS);

   rag_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (CW'(req_coef_index)),
      .wr_data (req_coef_value),
      .rd_en   (cmd.op == OP_RD),
      .rd_addr (cmd.coef_addr[CW-1:0]),
      .rd_data (coef_rd)
   );

   assign pw_wr    = (cmd.op == OP_START) || (cmd.op == OP_POW_WR);
   assign pw_waddr = (cmd.op == OP_START) ? '0 : cmd.pw_addr[PAW-1:0];
   assign pw_wdata = (cmd.op == OP_START) ? Q_ONE : rnd_sat.val;

   rag_ram #(.WIDTH(32), .DEPTH(PW_DEPTH)) u_pw_ram (
      .clock   (clock),
      .wr_en   (pw_wr),
      .wr_addr (pw_waddr),
      .wr_data (pw_wdata),
      .rd_en   (cmd.op == OP_RD),
      .rd_addr (cmd.pw_addr[PAW-1:0]),
      .rd_data (pw_rd)
   );

   // A slot never loaded since reset reads as zero.
   assign coef_eff = coef_vld_rd_ff ? coef_rd : 32'sd0;

   // Round to nearest, ties away from zero, on the magnitude.
   always_comb begin
      mag     = prod_ff[63] ? (64'd0 - $unsigned(prod_ff)) : $unsigned(prod_ff);
      rmag    = (mag + HALF) >> FRAC_BITS;
      rnd_pos = ACC_W'(rmag);
      rnd_u   = prod_ff[63] ? (ACC_W'(0) - rnd_pos) : rnd_pos;
      rnd     = $signed(rnd_u);
      rnd_sat = sat32(rnd);
      num_sat = sat32(acc_num_ff);
      den_sat = sat32(acc_den_ff + ACC_W'(Q_ONE));
      res_sat = sat32(ACC_W'(f_ff) - ACC_W'(y_ff));
   end

   always_comb begin
      case (cmd.op)
         OP_POW_MUL: begin
            mul_a = pw_cur_ff;
            mul_b = x_ff;
         end
         OP_FMUL: begin
            mul_a = pw_rd;
            mul_b = f_ff;
         end
         default: begin
            mul_a = coef_eff;
            mul_b = pw_rd;
         end
      endcase
   end

   always_comb begin
      case (cmd.op)
         OP_DIV_NUM: div_src = numq_ff;
         OP_DIV_PW:  div_src = pw_rd;
         default:    div_src = t_ff;
      endcase
      ua       = div_src[31] ? (32'd0 - $unsigned(div_src)) : $unsigned(div_src);
      ub       = den_ff[31] ? (32'd0 - $unsigned(den_ff)) : $unsigned(den_ff);
      dividend = (64'(ua) << FRAC_BITS) + 64'(ub[31:1]);
      dstep    = {drem_ff, dlo_ff[31]};
   end

   // Saturate the unsigned quotient magnitude with its sign.
   always_comb begin
      if (dovf_ff) begin
         div_val = dneg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         div_sat = 1'b1;
      end else if (dneg_ff) begin
         div_sat = dq_ff > 32'h8000_0000;
         div_val = div_sat ? 32'sh8000_0000 : $signed(32'd0 - dq_ff);
      end else begin
         div_sat = dq_ff[31];
         div_val = div_sat ? 32'sh7FFF_FFFF : $signed(dq_ff);
      end
      neg_sat = (div_val == 32'sh8000_0000);
      neg_val = neg_sat ? 32'sh7FFF_FFFF : -div_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_wr) begin
         coef_vld_ff[CW'(req_coef_index)] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_RD) begin
         coef_vld_rd_ff <= coef_vld_ff[cmd.coef_addr[CW-1:0]];
      end
      case (cmd.op)
         OP_START: begin
            x_ff       <= req_x_value;
            y_ff       <= req_y_value;
            pw_cur_ff  <= Q_ONE;
            acc_num_ff <= '0;
            acc_den_ff <= '0;
            common_ff  <= 1'b0;
            own_ff     <= 1'b0;
         end
         OP_POW_MUL, OP_TERM_MUL, OP_FMUL: begin
            prod_ff <= mul_a * mul_b;
         end
         OP_POW_WR: begin
            pw_cur_ff <= rnd_sat.val;
            common_ff <= common_ff | rnd_sat.ovf;
         end
         OP_TERM_ACC: begin
            if (cmd.acc_den) begin
               acc_den_ff <= acc_den_ff + rnd;
            end else begin
               acc_num_ff <= acc_num_ff + rnd;
            end
         end
         OP_FINISH: begin
            numq_ff   <= num_sat.val;
            den_ff    <= den_sat.val;
            common_ff <= common_ff | num_sat.ovf | den_sat.ovf;
         end
         OP_F_SAVE: begin
            f_ff      <= div_val;
            common_ff <= common_ff | div_sat;
         end
         OP_T_SAVE: begin
            t_ff   <= rnd_sat.val;
            own_ff <= own_ff | rnd_sat.ovf;
         end
         OP_EMIT: begin
            own_ff <= 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Restoring divider: one overflow check, then, unless that check overflows, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dprep_ff <= 1'b0;
      end else if ((cmd.op == OP_DIV_NUM) || (cmd.op == OP_DIV_PW) ||
                   (cmd.op == OP_DIV_T)) begin
         dbusy_ff <= 1'b1;
         dprep_ff <= 1'b1;
      end else if (dbusy_ff && dprep_ff) begin
         dprep_ff <= 1'b0;
         if (drem_ff >= dub_ff) begin
            dbusy_ff <= 1'b0;
         end
      end else if (dbusy_ff && (dcnt_ff == 6'd1)) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_DIV_NUM) || (cmd.op == OP_DIV_PW) || (cmd.op == OP_DIV_T)) begin
         dneg_ff <= div_src[31] ^ den_ff[31];
         dub_ff  <= ub;
         drem_ff <= dividend[63:32];
         dlo_ff  <= dividend[31:0];
         dovf_ff <= 1'b0;
      end else if (dbusy_ff && dprep_ff) begin
         dovf_ff <= (drem_ff >= dub_ff);
         dcnt_ff <= 6'd32;
      end else if (dbusy_ff) begin
         if (dstep >= {1'b0, dub_ff}) begin
            drem_ff <= 32'(dstep - {1'b0, dub_ff});
            dq_ff   <= {dq_ff[30:0], 1'b1};
         end else begin
            drem_ff <= dstep[31:0];
            dq_ff   <= {dq_ff[30:0], 1'b0};
         end
         dlo_ff  <= {dlo_ff[30:0], 1'b0};
         dcnt_ff <= dcnt_ff - 6'd1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         rsp_kind_ff <= cmd.kind;
         rsp_idx_ff  <= cmd.term_index;
         rsp_last_ff <= cmd.last;
         case (cmd.vsel)
            VS_RES: begin
               rsp_value_ff <= res_sat.val;
               rsp_err_ff   <= common_ff | res_sat.ovf;
            end
            VS_QPOS: begin
               rsp_value_ff <= div_val;
               rsp_err_ff   <= common_ff | own_ff | div_sat;
            end
            VS_QNEG: begin
               rsp_value_ff <= neg_val;
               rsp_err_ff   <= common_ff | own_ff | div_sat | neg_sat;
            end
            default: begin
               rsp_value_ff <= 32'sd0;
               rsp_err_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign status.den_zero = (den_ff == 32'sd0);
   assign status.div_busy = dbusy_ff;
   assign status.out_free = out_free;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_term_index = rsp_idx_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_div_error  = rsp_err_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* design/rag_ctrl.sv */
// Controller: configuration registers and the sequencer that drives the datapath.
module rag_ctrl import rag_pkg::*; #(
   parameter int MAX_TERMS = DEF_MAX_TERMS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [4:0] csr_wdata,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int JW = $clog2(MAX_TERMS + 2);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_POW_CHK   = 5'd1;
   localparam logic [4:0] S_POW_WR    = 5'd2;
   localparam logic [4:0] S_ACC_RD    = 5'd3;
   localparam logic [4:0] S_ACC_MUL   = 5'd4;
   localparam logic [4:0] S_ACC_ADD   = 5'd5;
   localparam logic [4:0] S_FIN       = 5'd6;
   localparam logic [4:0] S_CHK_DEN   = 5'd7;
   localparam logic [4:0] S_ZERO_EMIT = 5'd8;
   localparam logic [4:0] S_DIV_F     = 5'd9;
   localparam logic [4:0] S_RES_EMIT  = 5'd10;
   localparam logic [4:0] S_DER_RD    = 5'd11;
   localparam logic [4:0] S_DER_NDIV  = 5'd12;
   localparam logic [4:0] S_DER_FMUL  = 5'd13;
   localparam logic [4:0] S_DER_TSAVE = 5'd14;
   localparam logic [4:0] S_DER_TDIV  = 5'd15;
   localparam logic [4:0] S_DER_WAIT  = 5'd16;
   localparam logic [4:0] S_DER_EMIT  = 5'd17;

   logic [4:0] state_ff, state_in;
   logic [4:0] cfg_num_ff;
   logic [3:0] cfg_den_ff;
   logic [JW-1:0] j_ff, j_in, n_ff, top_ff, tot_ff;
   logic [JW-1:0] n_c, m_lim, m_c, top_c, pwi;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_num_ff <= 5'd1;
         cfg_den_ff <= 4'd0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_NUM_TERMS) begin
            cfg_num_ff <= csr_wdata;
         end else begin
            cfg_den_ff <= csr_wdata[3:0];
         end
      end
   end

   // Term counts beyond the table are clamped, numerator first.
   always_comb begin
      n_c   = (32'(cfg_num_ff) > MAX_TERMS) ? JW'(MAX_TERMS) : JW'(cfg_num_ff);
      m_lim = JW'(MAX_TERMS) - n_c;
      m_c   = (32'(cfg_den_ff) > 32'(m_lim)) ? m_lim : JW'(cfg_den_ff);
      top_c = ((n_c != '0) && ((n_c - JW'(1)) > m_c)) ? (n_c - JW'(1)) : m_c;
      pwi   = (j_ff < n_ff) ? j_ff : (j_ff - n_ff + JW'(1));
   end

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      j_in           = j_ff;
      cmd            = '0;
      cmd.op         = OP_NOP;
      cmd.coef_addr  = IDX_W'(j_ff);
      cmd.pw_addr    = IDX_W'(pwi);
      cmd.term_index = 4'(j_ff);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == REQ_LOAD) begin
                  cmd.op = OP_LOAD;
               end else begin
                  cmd.op   = OP_START;
                  j_in     = JW'(1);
                  state_in = S_POW_CHK;
               end
            end
         end
         S_POW_CHK: begin
            if (j_ff > top_ff) begin
               j_in     = '0;
               state_in = S_ACC_RD;
            end else begin
               cmd.op   = OP_POW_MUL;
               state_in = S_POW_WR;
            end
         end
         S_POW_WR: begin
            cmd.op      = OP_POW_WR;
            cmd.pw_addr = IDX_W'(j_ff);
            j_in        = j_ff + JW'(1);
            state_in    = S_POW_CHK;
         end
         S_ACC_RD: begin
            if (j_ff == tot_ff) begin
               state_in = S_FIN;
            end else begin
               cmd.op   = OP_RD;
               state_in = S_ACC_MUL;
            end
         end
         S_ACC_MUL: begin
            cmd.op   = OP_TERM_MUL;
            state_in = S_ACC_ADD;
         end
         S_ACC_ADD: begin
            cmd.op      = OP_TERM_ACC;
            cmd.acc_den = (j_ff >= n_ff);
            j_in        = j_ff + JW'(1);
            state_in    = S_ACC_RD;
         end
         S_FIN: begin
            cmd.op   = OP_FINISH;
            state_in = S_CHK_DEN;
         end
         S_CHK_DEN: begin
            j_in = '0;
            if (status.den_zero) begin
               state_in = S_ZERO_EMIT;
            end else begin
               cmd.op   = OP_DIV_NUM;
               state_in = S_DIV_F;
            end
         end
         S_ZERO_EMIT: begin
            // Result k of a zero denominator is term k-1, after the residual.
            cmd.vsel       = VS_ZERO;
            cmd.kind       = (j_ff == '0) ? KIND_RES : KIND_DER;
            cmd.term_index = (j_ff == '0) ? 4'd0 : 4'(j_ff - JW'(1));
            cmd.last       = (j_ff == tot_ff);
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               j_in   = j_ff + JW'(1);
               if (j_ff == tot_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV_F: begin
            if (!status.div_busy) begin
               cmd.op   = OP_F_SAVE;
               state_in = S_RES_EMIT;
            end
         end
         S_RES_EMIT: begin
            cmd.vsel       = VS_RES;
            cmd.kind       = KIND_RES;
            cmd.term_index = 4'd0;
            cmd.last       = (tot_ff == '0);
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = (tot_ff == '0) ? S_IDLE : S_DER_RD;
            end
         end
         S_DER_RD: begin
            cmd.op   = OP_RD;
            state_in = (j_ff < n_ff) ? S_DER_NDIV : S_DER_FMUL;
         end
         S_DER_NDIV: begin
            cmd.op   = OP_DIV_PW;
            state_in = S_DER_WAIT;
         end
         S_DER_FMUL: begin
            cmd.op   = OP_FMUL;
            state_in = S_DER_TSAVE;
         end
         S_DER_TSAVE: begin
            cmd.op   = OP_T_SAVE;
            state_in = S_DER_TDIV;
         end
         S_DER_TDIV: begin
            cmd.op   = OP_DIV_T;
            state_in = S_DER_WAIT;
         end
         S_DER_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_DER_EMIT;
            end
         end
         S_DER_EMIT: begin
            cmd.vsel = (j_ff < n_ff) ? VS_QPOS : VS_QNEG;
            cmd.kind = KIND_DER;
            cmd.last = ((j_ff + JW'(1)) == tot_ff);
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               j_in     = j_ff + JW'(1);
               state_in = ((j_ff + JW'(1)) == tot_ff) ? S_IDLE : S_DER_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == REQ_EVAL)) begin
         n_ff   <= n_c;
         top_ff <= top_c;
         tot_ff <= n_c + m_c;
      end
   end

endmodule

/* design/pade_residual_and_gradient.sv */
// A load is written into the coefficient table when it is accepted. An evaluate yields
// the residual, then one derivative per term, each of them one pass of the 32-step
// restoring divider.
// One item is in work at a time; the shared multiplier and the divider set the pace.
// Synchronous active-high reset clears the sequencer, the output valid, the table valid
// bits (the table then reads as zero) and sets N to one and M to zero.
module pade_residual_and_gradient import rag_pkg::*; #(
   parameter int MAX_TERMS = DEF_MAX_TERMS,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [3:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [3:0]         rsp_term_index,
   output logic signed [31:0] rsp_value,
   output logic               rsp_div_error,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [4:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rag_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd)
   );

   rag_dp #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_x_value    (req_x_value),
      .req_y_value    (req_y_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_term_index (rsp_term_index),
      .rsp_value      (rsp_value),
      .rsp_div_error  (rsp_div_error),
      .rsp_last       (rsp_last)
   );

endmodule

/* design/rag_checker.sv */
// Port-level checks on the Pade residual and gradient block, bound to the top level.
module rag_checker import rag_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_kind,
   input logic [3:0]         rsp_term_index,
   input logic signed [31:0] rsp_value,
   input logic               rsp_last
);

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_res_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RES) |-> rsp_term_index == 4'd0)
      else $error("residual carries a nonzero term index");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == REQ_LOAD) |=> req_ready)
      else $error("coefficient load did not complete in one cycle");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == REQ_EVAL) |=> !req_ready)
      else $error("input taken while an evaluation is in work");

   a_reset_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pade_residual_and_gradient rag_checker u_rag_checker (.*);

/* tb/tb_pade_residual_and_gradient.sv */
// Self-checking testbench for the Pade residual and gradient block.
module tb_pade_residual_and_gradient import rag_pkg::*; ();

   localparam int  TERMS     = 16;
   localparam int  FRAC      = 16;
   localparam longint ONE_Q  = 64'sd1 <<< FRAC;
   localparam int  LIMIT     = 4000000;
   localparam int  HOLD_LEN  = 3000;
   localparam int  RAND_ITEMS = 300;

   typedef struct packed {
      logic               kind;
      logic [3:0]         term;
      logic signed [31:0] value;
      logic               err;
      logic               last;
   } grad_word_type;

   typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type what;
      logic [3:0]   slot;
      logic [31:0]  coef;
      logic [31:0]  x;
      logic [31:0]  y;
      logic [4:0]   n;
      logic [4:0]   m;
      bit           typed;
      logic [31:0]  res_value;
      logic         res_err;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_op;
   logic [3:0]         req_coef_index;
   logic signed [31:0] req_coef_value;
   logic signed [31:0] req_x_value;
   logic signed [31:0] req_y_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_kind;
   logic [3:0]         rsp_term_index;
   logic signed [31:0] rsp_value;
   logic               rsp_div_error;
   logic               rsp_last;
   logic               csr_wr_en;
   logic               csr_index;
   logic [4:0]         csr_wdata;

   grad_word_type grad_expect_q[$];
   longint     coef_mem[TERMS];
   int         num_cfg;
   int         den_cfg;
   int         mismatches;
   int         cycles;
   int         snd_idle;
   int         rcv_stall;
   bit         hold_trigger;
   bit         hold_seen;
   int         hold_left;

   pade_residual_and_gradient DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint clip32(input longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Fixed-point product, rounded to nearest with ties away from zero.
   function automatic longint mul_q(input longint a, input longint b);
      longint p;
      longint mag;
      p = a * b;
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      return (p < 0) ? -mag : mag;
   endfunction

   function automatic longint div_q(input longint a, input longint b, inout bit flag);
      bit     neg;
      longint ua;
      longint ub;
      longint q;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      q = ((ua <<< FRAC) + ub / 2) / ub;
      if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
      return clip32(neg ? -q : q, flag);
   endfunction

   // Number of results that one evaluation yields under the current term counts.
   function automatic int result_count();
      int n;
      int m;
      n = (num_cfg > TERMS) ? TERMS : num_cfg;
      m = (den_cfg > TERMS - n) ? TERMS - n : den_cfg;
      return n + m + 1;
   endfunction

   function automatic void queue_word(input logic kind, input int term, input longint v,
                                      input bit err, input bit last);
      grad_word_type w;
      w.kind  = kind;
      w.term  = term[3:0];
      w.value = v[31:0];
      w.err   = err;
      w.last  = last;
      grad_expect_q.push_back(w);
   endfunction

   function automatic void predict_gradient(input logic signed [31:0] xv,
                                            input logic signed [31:0] yv);
      longint pw[TERMS + 1];
      longint acc;
      longint numv;
      longint denv;
      longint fv;
      longint t;
      int     n;
      int     m;
      int     top;
      bit     common;
      bit     own;
      n = (num_cfg > TERMS) ? TERMS : num_cfg;
      m = (den_cfg > TERMS - n) ? TERMS - n : den_cfg;
      common = 1'b0;
      top = m;
      if (n > 0 && n - 1 > top) top = n - 1;
      pw[0] = ONE_Q;
      for (int j = 1; j <= top; j++) pw[j] = clip32(mul_q(pw[j-1], longint'(xv)), common);
      acc = 0;
      for (int j = 0; j < n; j++) acc += mul_q(coef_mem[j], pw[j]);
      numv = clip32(acc, common);
      acc = 0;
      for (int j = 0; j < m; j++) acc += mul_q(coef_mem[n+j], pw[j+1]);
      denv = clip32(acc + ONE_Q, common);
      if (denv == 0) begin
         queue_word(KIND_RES, 0, 0, 1'b1, n + m == 0);
         for (int j = 0; j < n + m; j++) queue_word(KIND_DER, j, 0, 1'b1, j + 1 == n + m);
         return;
      end
      fv = div_q(numv, denv, common);
      own = 1'b0;
      t = clip32(fv - longint'(yv), own);
      queue_word(KIND_RES, 0, t, common | own, n + m == 0);
      for (int j = 0; j < n; j++) begin
         own = 1'b0;
         t = div_q(pw[j], denv, own);
         queue_word(KIND_DER, j, t, common | own, j + 1 == n + m);
      end
      for (int j = 0; j < m; j++) begin
         own = 1'b0;
         t = clip32(mul_q(pw[j+1], fv), own);
         t = div_q(t, denv, own);
         t = clip32(-t, own);
         queue_word(KIND_DER, n + j, t, common | own, n + j + 1 == n + m);
      end
   endfunction

   // Offers one item and returns at the edge where the transfer happens.
   task automatic send_item(input logic op, input logic [3:0] slot, input logic [31:0] coef,
                            input logic [31:0] xv, input logic [31:0] yv);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_coef_index <= slot;
      req_coef_value <= coef;
      req_x_value    <= xv;
      req_y_value    <= yv;
      do @(posedge clock); while (!req_ready);
      if (op == REQ_LOAD) coef_mem[slot] = longint'($signed(coef));
      else predict_gradient(xv, yv);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (grad_expect_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_terms(input logic [4:0] n, input logic [4:0] m);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_TERMS;
      csr_wdata <= n;
      @(posedge clock);
      csr_index <= CSR_DEN_TERMS;
      csr_wdata <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      num_cfg = n;
      den_cfg = m[3:0];
   endtask

   function automatic logic [31:0] rand_q();
      if ($urandom_range(3) != 0) return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      return $urandom;
   endfunction

   // Result checking and receiver back-pressure.
   always @(posedge clock) begin
      grad_word_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grad_expect_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result: kind %0d term %0d value %h", rsp_kind,
                           rsp_term_index, rsp_value);
            end else begin
               w = grad_expect_q.pop_front();
               if (w.kind !== rsp_kind || w.term !== rsp_term_index ||
                   w.value !== rsp_value || w.err !== rsp_div_error ||
                   w.last !== rsp_last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch: expected kind %0d term %0d value %h err %0d last %0d",
                              w.kind, w.term, w.value, w.err, w.last);
                     $display("          got kind %0d term %0d value %h err %0d last %0d",
                              rsp_kind, rsp_term_index, rsp_value, rsp_div_error, rsp_last);
                  end
               end
            end
         end
         if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_LEN;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type r;
      int        mode;
      int        per_phase;
      int        res_pos;
      logic [4:0] set_n[8];
      logic [4:0] set_m[8];
      set_n = '{5'd1, 5'd16, 5'd0, 5'd3, 5'd8, 5'd0, 5'd2, 5'd5};
      set_m = '{5'd0, 5'd0, 5'd16, 5'd2, 5'd8, 5'd15, 5'd14, 5'd31};
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = REQ_LOAD;
      req_coef_index = '0;
      req_coef_value = '0;
      req_x_value = '0;
      req_y_value = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_NUM_TERMS;
      csr_wdata = '0;
      hold_trigger = 1'b0;
      mismatches = 0;
      cycles = 0;
      snd_idle = 0;
      rcv_stall = 0;
      num_cfg = 1;
      den_cfg = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;

      // After reset: one numerator term, empty table, so f is zero.
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0, 32'h0, 0, 0, 1, 32'h0, 1'b0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h1234_5678, 32'h7FFF_FFFF, 0, 0, 1,
                       32'h8000_0001, 1'b0});
      // Largest coefficient minus the most negative y saturates the residual.
      rows.push_back('{ROW_LOAD, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0, 32'h8000_0000, 0, 0, 1,
                       32'h7FFF_FFFF, 1'b1});
      rows.push_back('{ROW_LOAD, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h7FFF_FFFF, 32'h0, 0, 0, 1,
                       32'h8000_0000, 1'b0});
      rows.push_back('{ROW_LOAD, 15, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_LOAD, 1, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0});
      // With D = 1 - x the point x = 1.0 gives a zero denominator.
      rows.push_back('{ROW_CFG, 0, 0, 0, 0, 5'd1, 5'd1, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0001_0000, 32'h5, 0, 0, 1, 32'h0, 1'b1});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h8000_0000, 32'h0001_0000, 0, 0, 0, 0, 0});
      // No terms at all: only the residual, marked last.
      rows.push_back('{ROW_CFG, 0, 0, 0, 0, 5'd0, 5'd0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0003_0000, 32'h0002_0000, 0, 0, 1,
                       32'hFFFE_0000, 1'b0});
      // Oversized counts clamp; powers of 2.0 overflow at the top.
      rows.push_back('{ROW_CFG, 0, 0, 0, 0, 5'd31, 5'd15, 0, 0, 0});
      rows.push_back('{ROW_LOAD, 7, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0002_0000, 32'h0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'hFFFF_8000, 32'h1, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_CFG, 0, 0, 0, 0, 5'd4, 5'd12, 0, 0, 0});
      rows.push_back('{ROW_LOAD, 10, 32'h0000_4000, 0, 0, 0, 0, 0, 0, 0});
      rows.push_back('{ROW_EVAL, 0, 0, 32'h0000_C000, 32'h8000_0000, 0, 0, 0, 0, 0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         case (r.what)
            ROW_CFG: begin
               write_terms(r.n, r.m);
            end
            ROW_LOAD: begin
               send_item(REQ_LOAD, r.slot, r.coef, '0, '0);
            end
            default: begin
               send_item(REQ_EVAL, '0, '0, r.x, r.y);
               if (r.typed) begin
                  // The residual heads this item's results at the back of the queue.
                  res_pos = grad_expect_q.size() - result_count();
                  grad_expect_q[res_pos].value = r.res_value;
                  grad_expect_q[res_pos].err   = r.res_err;
               end
            end
         endcase
      end

      per_phase = RAND_ITEMS / 8;
      for (int p = 0; p < 8; p++) begin
         write_terms(set_n[p], set_m[p]);
         mode = p % 4;
         snd_idle  = (mode == 1) ? 67 : (mode == 3) ? 27 : 0;
         rcv_stall = (mode == 2) ? 67 : (mode == 3) ? 27 : 0;
         if (p == 1) hold_trigger = ~hold_trigger;
         for (int k = 0; k < per_phase; k++) begin
            if (p == 3 && k == per_phase / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (grad_expect_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(9) < 4)
               send_item(REQ_LOAD, 4'($urandom_range(15)), rand_q(), $urandom, $urandom);
            else
               send_item(REQ_EVAL, 4'($urandom_range(15)), $urandom, rand_q(), rand_q());
         end
      end

      wait_idle();
      repeat (1000) @(posedge clock);
      if (mismatches == 0 && grad_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/rag_pkg.sv
design/rag_ram.sv
design/rag_dp.sv
design/rag_ctrl.sv
design/pade_residual_and_gradient.sv
design/rag_checker.sv
tb/tb_pade_residual_and_gradient.sv
